### design/rmtc_pkg.sv
// types, codes and the sine table shared by the motion controller core
// no dependencies
`default_nettype none
package rmtc_pkg;

    localparam logic [2:0] ACT_MOVE     = 3'd0;
    localparam logic [2:0] ACT_TURN     = 3'd1;
    localparam logic [2:0] ACT_TURN_TO  = 3'd2;
    localparam logic [2:0] ACT_TICK     = 3'd3;
    localparam logic [2:0] ACT_SET_POSE = 3'd4;

    localparam logic ITER_DIV  = 1'b0;
    localparam logic ITER_SQRT = 1'b1;

    localparam int ITER_AW = 34;
    localparam int ITER_BW = 17;
    localparam int ITER_RW = 20;

    typedef struct packed {
        logic                 start;
        logic                 mode;
        logic [ITER_AW-1:0]   a;
        logic [ITER_BW-1:0]   b;
    } iter_req_t;

    typedef struct packed {
        logic                 done;
        logic [ITER_AW-1:0]   q;
        logic [ITER_RW-1:0]   rem;
    } iter_rsp_t;

    // round(sin(k deg) * 32768), k = 0..90
    function automatic logic [15:0] sin_q15(input logic [6:0] k);
        logic [15:0] v;
        case (k)
            7'd0: v = 16'd0;       7'd1: v = 16'd572;     7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;    7'd4: v = 16'd2286;    7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;    7'd7: v = 16'd3993;    7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;    7'd10: v = 16'd5690;   7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;   7'd13: v = 16'd7371;   7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;   7'd16: v = 16'd9032;   7'd17: v = 16'd9580;
            7'd18: v = 16'd10126;  7'd19: v = 16'd10668;  7'd20: v = 16'd11207;
            7'd21: v = 16'd11743;  7'd22: v = 16'd12275;  7'd23: v = 16'd12803;
            7'd24: v = 16'd13328;  7'd25: v = 16'd13848;  7'd26: v = 16'd14365;
            7'd27: v = 16'd14876;  7'd28: v = 16'd15384;  7'd29: v = 16'd15886;
            7'd30: v = 16'd16384;  7'd31: v = 16'd16877;  7'd32: v = 16'd17364;
            7'd33: v = 16'd17847;  7'd34: v = 16'd18324;  7'd35: v = 16'd18795;
            7'd36: v = 16'd19261;  7'd37: v = 16'd19720;  7'd38: v = 16'd20174;
            7'd39: v = 16'd20622;  7'd40: v = 16'd21063;  7'd41: v = 16'd21498;
            7'd42: v = 16'd21926;  7'd43: v = 16'd22348;  7'd44: v = 16'd22763;
            7'd45: v = 16'd23170;  7'd46: v = 16'd23571;  7'd47: v = 16'd23965;
            7'd48: v = 16'd24351;  7'd49: v = 16'd24730;  7'd50: v = 16'd25102;
            7'd51: v = 16'd25466;  7'd52: v = 16'd25822;  7'd53: v = 16'd26170;
            7'd54: v = 16'd26510;  7'd55: v = 16'd26842;  7'd56: v = 16'd27166;
            7'd57: v = 16'd27482;  7'd58: v = 16'd27789;  7'd59: v = 16'd28088;
            7'd60: v = 16'd28378;  7'd61: v = 16'd28660;  7'd62: v = 16'd28932;
            7'd63: v = 16'd29197;  7'd64: v = 16'd29452;  7'd65: v = 16'd29698;
            7'd66: v = 16'd29935;  7'd67: v = 16'd30163;  7'd68: v = 16'd30382;
            7'd69: v = 16'd30592;  7'd70: v = 16'd30792;  7'd71: v = 16'd30983;
            7'd72: v = 16'd31164;  7'd73: v = 16'd31336;  7'd74: v = 16'd31499;
            7'd75: v = 16'd31651;  7'd76: v = 16'd31795;  7'd77: v = 16'd31928;
            7'd78: v = 16'd32052;  7'd79: v = 16'd32166;  7'd80: v = 16'd32270;
            7'd81: v = 16'd32365;  7'd82: v = 16'd32449;  7'd83: v = 16'd32524;
            7'd84: v = 16'd32588;  7'd85: v = 16'd32643;  7'd86: v = 16'd32688;
            7'd87: v = 16'd32723;  7'd88: v = 16'd32748;  7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // sine of a whole-degree angle in 0..359, q15 scale
    function automatic logic signed [16:0] sin_deg(input logic [8:0] h);
        logic [8:0]  idx;
        logic        neg;
        logic [16:0] mag;
        if (h <= 9'd90) begin
            idx = h;
            neg = 1'b0;
        end else if (h <= 9'd180) begin
            idx = 9'd180 - h;
            neg = 1'b0;
        end else if (h <= 9'd270) begin
            idx = h - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - h;
            neg = 1'b1;
        end
        mag = {1'b0, sin_q15(idx[6:0])};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

### design/rmtc_iter.sv
// shared radix-2 divide / square root unit, one bit of result per cycle
// depends on rmtc_pkg
`default_nettype none
module rmtc_iter (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  rmtc_pkg::iter_req_t  req,
    output rmtc_pkg::iter_rsp_t  rsp
);
    import rmtc_pkg::*;

    localparam logic [5:0] DIV_STEPS  = 6'(ITER_AW);
    localparam logic [5:0] SQRT_STEPS = 6'(ITER_AW / 2);

    logic                busy_reg;
    logic                done_reg;
    logic                mode_reg;
    logic [5:0]          cnt_reg;
    logic [ITER_AW-1:0]  w_reg;
    logic [ITER_AW-1:0]  q_reg;
    logic [ITER_RW-1:0]  rem_reg;
    logic [ITER_BW-1:0]  b_reg;

    logic [ITER_RW-1:0]  sh;
    logic [ITER_RW-1:0]  tr;
    logic                ge;

    // one shared compare and subtract
    always_comb begin
        if (mode_reg == ITER_DIV) begin
            sh = {rem_reg[ITER_RW-2:0], w_reg[ITER_AW-1]};
            tr = {{(ITER_RW-ITER_BW){1'b0}}, b_reg};
        end else begin
            sh = {rem_reg[ITER_RW-3:0], w_reg[ITER_AW-1:ITER_AW-2]};
            tr = {q_reg[ITER_RW-3:0], 2'b01};
        end
        ge = (sh >= tr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                cnt_reg  <= (req.mode == ITER_DIV) ? DIV_STEPS : SQRT_STEPS;
                w_reg    <= req.a;
                b_reg    <= req.b;
                q_reg    <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? (sh - tr) : sh;
                q_reg   <= {q_reg[ITER_AW-2:0], ge};
                if (mode_reg == ITER_DIV) begin
                    w_reg <= {w_reg[ITER_AW-2:0], 1'b0};
                end else begin
                    w_reg <= {w_reg[ITER_AW-3:0], 2'b00};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

### design/robot_move_turn_controller_core.sv
// motion controller core: move, relative turn, absolute turn, tick and set pose handling
// depends on rmtc_pkg and rmtc_iter
`default_nettype none
// usage
//  - s_ channel carries one request: action in s_tuser, operands in s_tdata
//  - m_ channel returns exactly one result per request: drive flag in m_tuser,
//    velocities, rate, busy, stored pose and speed in m_tdata
//  - cfg_we / cfg_wdata write speed_setting; write only while idle
//  - one request at a time: s_tready is high only while the sequencer is idle
//  - turn, set_pose, idle tick and turn tick go from dispatch straight to output;
//    turn_to and a move request reduce mod 360 by reciprocal multiply;
//    a driving move tick runs a 17-step root, two 34-step divides and a
//    17-step root
//  - the shared divide / root unit, one result bit per cycle, sets the length of a
//    driving move tick; an 18x18 multiplier with a registered product feeds it and also
//    does the mod 360 reduction
//  - reset clears pose, command state, speed_setting and the output valid flag
//  - if the receiver stalls, the result holds in the output register; the sequencer
//    still takes the next request but waits before handing its result over
module robot_move_turn_controller_core (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [87:0]  s_tdata,  // distance, turn_angle, turn_rate, meas_x, meas_y, meas_heading
    input  wire  [2:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [111:0] m_tdata,  // vel_x, vel_y, rate_out, busy_res, pos_x, pos_y, heading, speed
    output logic         m_tuser,  // drive_valid
    input  wire          cfg_we,
    input  wire  [15:0]  cfg_wdata
);
    import rmtc_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DISP = 5'd1;
    localparam logic [4:0] ST_HMOD = 5'd2;
    localparam logic [4:0] ST_MCOS = 5'd3;
    localparam logic [4:0] ST_ACOS = 5'd4;
    localparam logic [4:0] ST_MSIN = 5'd5;
    localparam logic [4:0] ST_ASIN = 5'd6;
    localparam logic [4:0] ST_TMOD = 5'd7;
    localparam logic [4:0] ST_MDX  = 5'd8;
    localparam logic [4:0] ST_MDY  = 5'd9;
    localparam logic [4:0] ST_CHK  = 5'd10;
    localparam logic [4:0] ST_ROOT = 5'd11;
    localparam logic [4:0] ST_MVX  = 5'd12;
    localparam logic [4:0] ST_DVX  = 5'd13;
    localparam logic [4:0] ST_WVX  = 5'd14;
    localparam logic [4:0] ST_MVY  = 5'd15;
    localparam logic [4:0] ST_DVY  = 5'd16;
    localparam logic [4:0] ST_WVY  = 5'd17;
    localparam logic [4:0] ST_SVX  = 5'd18;
    localparam logic [4:0] ST_SVY  = 5'd19;
    localparam logic [4:0] ST_SQ2  = 5'd20;
    localparam logic [4:0] ST_WSQ  = 5'd21;
    localparam logic [4:0] ST_OUT  = 5'd22;
    localparam logic [4:0] ST_HRED = 5'd23;
    localparam logic [4:0] ST_TRED = 5'd24;

    // ceil(2^24 / 360): quotient exact for operands below 74898
    localparam logic signed [17:0] RECIP_360 = 18'sd46604;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767) return 16'sh7fff;
        if (v < -21'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    logic [4:0]          state_reg;

    // latched request
    logic [2:0]          act_reg;
    logic signed [15:0]  dist_reg;
    logic [9:0]          tangle_reg;
    logic signed [10:0]  trate_reg;
    logic signed [15:0]  mx_reg;
    logic signed [15:0]  my_reg;
    logic signed [15:0]  mh_reg;

    // architectural state
    logic [15:0]         speed_setting_reg;
    logic                cmd_is_turn_reg;
    logic                in_progress_reg;
    logic signed [16:0]  arg_first_reg;
    logic signed [16:0]  arg_second_reg;
    logic signed [16:0]  arg_third_reg;
    logic signed [15:0]  pose_x_reg;
    logic signed [15:0]  pose_y_reg;
    logic signed [15:0]  pose_h_reg;
    logic [15:0]         last_speed_reg;

    // working registers
    logic [8:0]          h_reg;
    logic signed [16:0]  dx_reg;
    logic signed [16:0]  dy_reg;
    logic signed [35:0]  prod_reg;
    logic [33:0]         acc_reg;
    logic [16:0]         root_reg;
    logic signed [16:0]  vx_reg;
    logic signed [16:0]  vy_reg;
    logic                res_valid_reg;
    logic signed [10:0]  res_rate_reg;

    // output register
    logic                m_tvalid_reg;
    logic [111:0]        m_tdata_reg;
    logic                m_tuser_reg;

    iter_req_t           iter_req;
    iter_rsp_t           iter_rsp;

    rmtc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .rsp     (iter_rsp)
    );

    // request field unpacking
    logic signed [15:0]  in_dist;
    logic [9:0]          in_tangle;
    logic signed [10:0]  in_trate;
    logic signed [15:0]  in_mx;
    logic signed [15:0]  in_my;
    logic signed [15:0]  in_mh;

    assign in_dist   = s_tdata[15:0];
    assign in_tangle = s_tdata[25:16];
    assign in_trate  = s_tdata[36:26];
    assign in_mx     = s_tdata[52:37];
    assign in_my     = s_tdata[68:53];
    assign in_mh     = s_tdata[84:69];

    // heading reduction operands
    logic signed [16:0]  ph_ext;
    logic signed [16:0]  ph_neg;
    logic [16:0]         ph_abs;
    logic signed [16:0]  tdiff;
    logic signed [16:0]  tdiff_neg;
    logic [16:0]         tdiff_abs;

    assign ph_ext    = 17'(pose_h_reg);
    assign ph_neg    = -ph_ext;
    assign ph_abs    = pose_h_reg[15] ? ph_neg : ph_ext;
    assign tdiff     = $signed({7'b0, tangle_reg}) - ph_ext;
    assign tdiff_neg = -tdiff;
    assign tdiff_abs = tdiff[16] ? tdiff_neg : tdiff;

    // magnitude remainder by 360 from the registered reciprocal product
    logic [16:0]         mod_in;
    logic [6:0]          mod_q;
    logic [16:0]         mod_full;
    logic [8:0]          mod_r;

    assign mod_in   = (act_reg == ACT_MOVE) ? ph_abs : tdiff_abs;
    assign mod_q    = prod_reg[30:24];
    assign mod_full = mod_in - (17'(mod_q) * 17'd360);
    assign mod_r    = mod_full[8:0];

    // shared multiplier with operand select
    logic signed [17:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [35:0]  mul_p;
    logic [8:0]          cos_idx;

    assign cos_idx = (h_reg >= 9'd270) ? (h_reg - 9'd270) : (h_reg + 9'd90);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HMOD, ST_TMOD: begin
                mul_a = 18'(mod_in);
                mul_b = RECIP_360;
            end
            ST_MCOS: begin
                mul_a = 18'(sin_deg(cos_idx));
                mul_b = 18'(dist_reg);
            end
            ST_MSIN: begin
                mul_a = 18'(sin_deg(h_reg));
                mul_b = 18'(dist_reg);
            end
            ST_MDX: begin
                mul_a = 18'(dx_reg);
                mul_b = 18'(dx_reg);
            end
            ST_MDY: begin
                mul_a = 18'(dy_reg);
                mul_b = 18'(dy_reg);
            end
            ST_MVX: begin
                mul_a = 18'(dx_reg);
                mul_b = 18'(arg_third_reg);
            end
            ST_MVY: begin
                mul_a = 18'(dy_reg);
                mul_b = 18'(arg_third_reg);
            end
            ST_SVX: begin
                mul_a = 18'(vx_reg);
                mul_b = 18'(vx_reg);
            end
            ST_SVY: begin
                mul_a = 18'(vy_reg);
                mul_b = 18'(vy_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product divided by 32768, truncated toward zero
    logic signed [35:0]  prod_adj;
    logic signed [20:0]  prod_q;
    logic signed [20:0]  tgt_x;
    logic signed [20:0]  tgt_y;

    assign prod_adj = prod_reg + (prod_reg[35] ? 36'sd32767 : 36'sd0);
    assign prod_q   = prod_adj[35:15];
    assign tgt_x    = 21'(pose_x_reg) + prod_q;
    assign tgt_y    = 21'(pose_y_reg) + prod_q;

    logic signed [35:0]  prod_neg;
    logic [33:0]         prod_abs;
    logic [33:0]         sum_sq;

    assign prod_neg = -prod_reg;
    assign prod_abs = prod_reg[35] ? prod_neg[33:0] : prod_reg[33:0];
    assign sum_sq   = acc_reg + prod_reg[33:0];

    // turn completion test
    logic signed [18:0]  hdiff;
    logic signed [18:0]  hdiff_abs;
    logic                turn_done;

    assign hdiff     = 19'(mh_reg) - 19'(arg_second_reg);
    assign hdiff_abs = hdiff[18] ? -hdiff : hdiff;
    assign turn_done = (hdiff_abs >= 19'(arg_first_reg));

    // quotient as a positive value; the sign of the numerator is applied when it is stored
    logic signed [16:0]  q_pos;
    assign q_pos = $signed({1'b0, iter_rsp.q[15:0]});

    always_comb begin
        iter_req.start = 1'b0;
        iter_req.mode  = ITER_DIV;
        iter_req.a     = '0;
        iter_req.b     = '0;
        case (state_reg)
            ST_CHK: begin
                iter_req.start = (sum_sq > 34'd100);
                iter_req.mode  = ITER_SQRT;
                iter_req.a     = sum_sq;
            end
            ST_DVX, ST_DVY: begin
                iter_req.start = 1'b1;
                iter_req.a     = prod_abs;
                iter_req.b     = root_reg;
            end
            ST_SQ2: begin
                iter_req.start = 1'b1;
                iter_req.mode  = ITER_SQRT;
                iter_req.a     = sum_sq;
            end
            default: begin
                iter_req.start = 1'b0;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            speed_setting_reg <= '0;
            cmd_is_turn_reg   <= 1'b0;
            in_progress_reg   <= 1'b0;
            arg_first_reg     <= '0;
            arg_second_reg    <= '0;
            arg_third_reg     <= '0;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            pose_h_reg        <= '0;
            last_speed_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                speed_setting_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg    <= s_tuser;
                        dist_reg   <= in_dist;
                        tangle_reg <= in_tangle;
                        trate_reg  <= in_trate;
                        mx_reg     <= in_mx;
                        my_reg     <= in_my;
                        mh_reg     <= in_mh;
                        state_reg  <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    res_valid_reg <= 1'b0;
                    res_rate_reg  <= '0;
                    vx_reg        <= '0;
                    vy_reg        <= '0;
                    dx_reg        <= arg_first_reg - 17'(mx_reg);
                    dy_reg        <= arg_second_reg - 17'(my_reg);
                    state_reg     <= ST_OUT;
                    case (act_reg)
                        ACT_MOVE:    state_reg <= ST_HMOD;
                        ACT_TURN_TO: state_reg <= ST_TMOD;
                        ACT_TURN: begin
                            arg_first_reg   <= 17'({7'b0, tangle_reg});
                            arg_second_reg  <= ph_ext;
                            arg_third_reg   <= 17'(trate_reg);
                            cmd_is_turn_reg <= 1'b1;
                            in_progress_reg <= 1'b1;
                        end
                        ACT_TICK: begin
                            if (in_progress_reg) begin
                                res_valid_reg <= 1'b1;
                                if (cmd_is_turn_reg) begin
                                    // turn tick: finish or keep driving the rate
                                    pose_h_reg <= mh_reg;
                                    if (turn_done) begin
                                        in_progress_reg <= 1'b0;
                                    end else begin
                                        res_rate_reg <= arg_third_reg[10:0];
                                    end
                                end else begin
                                    state_reg <= ST_MDX;
                                end
                            end
                        end
                        ACT_SET_POSE: begin
                            pose_x_reg <= mx_reg;
                            pose_y_reg <= my_reg;
                            pose_h_reg <= mh_reg;
                        end
                        default: begin
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_HMOD: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_HRED;
                end
                ST_HRED: begin
                    // heading into 0..359
                    h_reg <= (pose_h_reg[15] && (mod_r != 9'd0)) ?
                             (9'd360 - mod_r) : mod_r;
                    state_reg <= ST_MCOS;
                end
                ST_MCOS: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACOS;
                end
                ST_ACOS: begin
                    arg_first_reg <= 17'(sat16(tgt_x));
                    state_reg     <= ST_MSIN;
                end
                ST_MSIN: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ASIN;
                end
                ST_ASIN: begin
                    arg_second_reg  <= 17'(sat16(tgt_y));
                    arg_third_reg   <= 17'({1'b0, speed_setting_reg});
                    cmd_is_turn_reg <= 1'b0;
                    in_progress_reg <= 1'b1;
                    state_reg       <= ST_OUT;
                end
                ST_TMOD: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_TRED;
                end
                ST_TRED: begin
                    // shortest signed turn from the truncated remainder
                    if (mod_r > 9'd180) begin
                        arg_first_reg <= 17'(9'd360 - mod_r);
                        arg_third_reg <= tdiff[16] ? 17'sd360 : -17'sd360;
                    end else begin
                        arg_first_reg <= 17'(mod_r);
                        arg_third_reg <= (tdiff[16] && (mod_r != 9'd0)) ?
                                         -17'sd360 : 17'sd360;
                    end
                    arg_second_reg  <= ph_ext;
                    cmd_is_turn_reg <= 1'b1;
                    in_progress_reg <= 1'b1;
                    state_reg       <= ST_OUT;
                end
                ST_MDX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MDY;
                end
                ST_MDY: begin
                    acc_reg   <= prod_reg[33:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    pose_x_reg <= mx_reg;
                    pose_y_reg <= my_reg;
                    if (sum_sq > 34'd100) begin
                        state_reg <= ST_ROOT;
                    end else begin
                        // close enough: the move completes
                        in_progress_reg <= 1'b0;
                        last_speed_reg  <= '0;
                        state_reg       <= ST_OUT;
                    end
                end
                ST_ROOT: begin
                    if (iter_rsp.done) begin
                        root_reg  <= iter_rsp.q[16:0];
                        state_reg <= ST_MVX;
                    end
                end
                ST_MVX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DVX;
                end
                ST_DVX: begin
                    state_reg <= ST_WVX;
                end
                ST_WVX: begin
                    if (iter_rsp.done) begin
                        vx_reg    <= dx_reg[16] ? -q_pos : q_pos;
                        state_reg <= ST_MVY;
                    end
                end
                ST_MVY: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DVY;
                end
                ST_DVY: begin
                    state_reg <= ST_WVY;
                end
                ST_WVY: begin
                    if (iter_rsp.done) begin
                        vy_reg    <= dy_reg[16] ? -q_pos : q_pos;
                        state_reg <= ST_SVX;
                    end
                end
                ST_SVX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SVY;
                end
                ST_SVY: begin
                    acc_reg   <= prod_reg[33:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    state_reg <= ST_WSQ;
                end
                ST_WSQ: begin
                    if (iter_rsp.done) begin
                        last_speed_reg <= (iter_rsp.q[33:16] != '0) ?
                                          16'hffff : iter_rsp.q[15:0];
                        state_reg      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hand the result over once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_valid_reg;
                        m_tdata_reg  <= {2'b00, last_speed_reg, pose_h_reg, pose_y_reg,
                                         pose_x_reg, in_progress_reg, res_rate_reg,
                                         vy_reg, vx_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

### design/rmtc_checker.sv
// port-level checks for the motion controller core, bound to the top level
// depends on robot_move_turn_controller_core
`default_nettype none
module rmtc_checker (
    input wire          aclk,
    input wire          aresetn,
    input wire          s_tvalid,
    input wire          s_tready,
    input wire          m_tvalid,
    input wire          m_tready,
    input wire [111:0]  m_tdata,
    input wire          m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // velocities and rate only come with a drive flag
    a_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[44:0] == 45'd0))
        else $error("drive values without drive flag");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind robot_move_turn_controller_core rmtc_checker u_rmtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
